// ===== design/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the trapezoidal coulomb counter.
// ----------------------------------------------------------------------------
package tcc_pkg;

   // Request action codes
   localparam logic [1:0] ACT_SAMPLE  = 2'd0;
   localparam logic [1:0] ACT_SET     = 2'd1;
   localparam logic [1:0] ACT_RESTORE = 2'd2;

   // CSR register index (paddr[2])
   localparam logic REG_INTERVAL = 1'b0;
   localparam logic REG_DELTA    = 1'b1;

   localparam logic [31:0] INTERVAL_RESET = 32'd60000;
   localparam logic [31:0] DELTA_RESET    = 32'd1000;

   // Serial multiplier: one bit of dt per cycle
   localparam int          DT_W      = 16;
   localparam int          MUL_CNT_W = 5;
   localparam logic [MUL_CNT_W-1:0] MUL_STEPS = 5'd16;

   // Serial divider
   localparam int          DIV_W       = 20;
   localparam int          DIV_CNT_W   = 7;
   localparam int          NUM_W       = 49;
   localparam logic [DIV_W-1:0]     DIVISOR_Q  = 20'd360000;
   localparam logic [DIV_W-1:0]     DIVISOR_O  = 20'd10;
   localparam logic [DIV_CNT_W-1:0] QDIV_STEPS = 7'd49;
   localparam logic [DIV_CNT_W-1:0] ODIV_STEPS = 7'd64;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] count;
      logic [DIV_W-1:0]     divisor;
   } div_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_NUM,
      ST_QDIV_GO,
      ST_QDIV_WAIT,
      ST_APPLY,
      ST_DIFF,
      ST_MAG,
      ST_CHECK,
      ST_ODIV_GO,
      ST_ODIV_WAIT,
      ST_SAT,
      ST_DONE
   } tcc_state_type;

endpackage

// ===== design/tcc_mul.sv =====
// ----------------------------------------------------------------------------
// tcc_mul
// Bit-serial signed x unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tcc_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [31:0]                     multiplicand, // signed
   input  logic [tcc_pkg::DT_W-1:0]        multiplier,   // unsigned
   output logic [47:0]                     product,      // signed
   output logic                            busy,
   output logic                            done
);

   logic [tcc_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [32:0]                   hi_ff, hi_in;
   logic [tcc_pkg::DT_W-1:0]      lo_ff, lo_in;
   logic [31:0]                   mcand_ff, mcand_in;
   logic [32:0]                   hi_sum;

   assign busy = (cnt_ff != '0);
   assign done = busy && (cnt_ff == tcc_pkg::MUL_CNT_W'(1));

   // partial product add, then arithmetic shift right of {hi, lo}
   assign hi_sum = lo_ff[0] ? (hi_ff + {mcand_ff[31], mcand_ff}) : hi_ff;

   always_comb begin
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      if (start) begin
         cnt_in   = tcc_pkg::MUL_STEPS;
         hi_in    = '0;
         lo_in    = multiplier;
         mcand_in = multiplicand;
      end else if (busy) begin
         cnt_in = cnt_ff - tcc_pkg::MUL_CNT_W'(1);
         hi_in  = {hi_sum[32], hi_sum[32:1]};
         lo_in  = {hi_sum[0], lo_ff[tcc_pkg::DT_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
   end

   assign product = {hi_ff[31:0], lo_ff};

endmodule

// ===== design/tcc_div.sv =====
// ----------------------------------------------------------------------------
// tcc_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  tcc_pkg::div_cmd_type        cmd,
   input  logic [63:0]                 dividend,  // msb-aligned
   output logic [63:0]                 quotient,  // low count bits
   output logic [tcc_pkg::DIV_W-1:0]   remainder,
   output logic                        busy,
   output logic                        done
);

   logic [tcc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]                   q_ff, q_in;
   logic [tcc_pkg::DIV_W-1:0]     r_ff, r_in;
   logic [tcc_pkg::DIV_W-1:0]     d_ff, d_in;
   logic [tcc_pkg::DIV_W-1:0]     r_shift;
   logic                          fits;

   assign busy    = (cnt_ff != '0);
   assign done    = busy && (cnt_ff == tcc_pkg::DIV_CNT_W'(1));
   // remainder stays below the divisor, so its top bit is always clear
   assign r_shift = {r_ff[tcc_pkg::DIV_W-2:0], q_ff[63]};
   assign fits    = (r_shift >= d_ff);

   always_comb begin
      cnt_in = cnt_ff;
      q_in   = q_ff;
      r_in   = r_ff;
      d_in   = d_ff;
      if (cmd.start) begin
         cnt_in = cmd.count;
         q_in   = dividend;
         r_in   = '0;
         d_in   = cmd.divisor;
      end else if (busy) begin
         cnt_in = cnt_ff - tcc_pkg::DIV_CNT_W'(1);
         q_in   = {q_ff[62:0], fits};
         r_in   = fits ? (r_shift - d_ff) : r_shift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

// ===== design/trapezoidal_coulomb_counter_unit.sv =====
// ----------------------------------------------------------------------------
// trapezoidal_coulomb_counter_unit
// Trapezoidal coulomb counter: integrates current samples into charge.
// ----------------------------------------------------------------------------
// Flow from the accepting edge to rsp_tvalid: an integrating sample runs the serial
//   multiply, the divide by 360000 and then the divide by 10; set, restore, first sample,
//   zero dt and unused action run the divide by 10 only; an uninitialised beat skips both.
// One item at a time: next beat taken the cycle after the result moves to the
//   output register.
// Synchronous active-high reset clears all counter state, CSRs to defaults.
// ----------------------------------------------------------------------------
module trapezoidal_coulomb_counter_unit (
   input  logic        clock,
   input  logic        reset,

   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // [31:0] sample_current, [47:32] dt_ms,
                                   // [79:48] preset_mah_x100
   input  logic [1:0]  req_tuser,  // [1:0] action

   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] charge_mah_x100, [32] save_request,
                                   // [39:33] zero
   output logic        rsp_tuser,  // [0] status

   // CSR port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   tcc_pkg::tcc_state_type state_ff, state_in;

   // CSRs
   logic [31:0] interval_ff;
   logic [31:0] thr_ff;

   // counter state
   logic [63:0] acc_ff;       // charge, 0.001 mAh
   logic [19:0] rem_ff;       // signed carried remainder
   logic [31:0] prev_ff;      // previous current sample
   logic        have_prev_ff;
   logic        ready_ff;     // restore seen
   logic [63:0] saved_ff;     // charge at last save
   logic [31:0] tss_ff;       // ms since last save

   // latched beat
   logic [1:0]  action_ff;
   logic [31:0] cur_ff;
   logic [15:0] dt_ff;
   logic [31:0] preset_ff;

   // working registers
   logic [31:0] avg_ff;
   logic [48:0] num_ff;
   logic [63:0] diff_ff;
   logic [63:0] mag_ff;
   logic        status_ff;
   logic        save_ff;
   logic [31:0] charge_ff;

   // output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_charge_ff;
   logic        rsp_save_ff;
   logic        rsp_status_ff;

   logic        req_beat;
   logic        rsp_load;
   logic        csr_write;

   logic        mul_start;
   logic [47:0] mul_product;
   logic        mul_busy;
   logic        mul_done;

   tcc_pkg::div_cmd_type div_cmd;
   logic [63:0] div_dividend;
   logic [63:0] div_quotient;
   logic [tcc_pkg::DIV_W-1:0] div_remainder;
   logic        div_busy;
   logic        div_done;

   logic [63:0] preset_x10;
   logic [63:0] preset_ext;
   logic [32:0] cur_sum;
   logic [31:0] avg_next;
   logic [48:0] num_abs;
   logic [63:0] acc_abs;
   logic        integrate;
   logic [63:0] delta_mask;
   logic [19:0] rem_signed;
   logic [31:0] sat_charge;
   logic        hit_time;
   logic        hit_delta;

   // ------------------------------------------------------------------------
   // Handshakes
   // ------------------------------------------------------------------------
   assign req_beat  = req_tvalid && req_tready;
   // result moves to the output register once that register is free
   assign rsp_load  = (state_ff == tcc_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == tcc_pkg::REG_DELTA) ? thr_ff : interval_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_save_ff, rsp_charge_ff};
   assign rsp_tuser  = rsp_status_ff;

   // ------------------------------------------------------------------------
   // Datapath helpers
   // ------------------------------------------------------------------------
   // preset * 10 as 8x + 2x
   assign preset_ext = {{32{preset_ff[31]}}, preset_ff};
   assign preset_x10 = {preset_ext[60:0], 3'b000} + {preset_ext[62:0], 1'b0};

   // average truncated toward zero: floor, plus one when negative and odd
   assign cur_sum  = {prev_ff[31], prev_ff} + {cur_ff[31], cur_ff};
   assign avg_next = cur_sum[32:1] + {31'd0, cur_sum[32] & cur_sum[0]};

   assign integrate = have_prev_ff && (dt_ff != 16'd0);

   assign num_abs = num_ff[48] ? (~num_ff + 49'd1) : num_ff;
   assign acc_abs = acc_ff[63] ? (~acc_ff + 64'd1) : acc_ff;

   // signed quotient folded into the accumulator add
   assign delta_mask = {64{num_ff[48]}};
   assign rem_signed = num_ff[48] ? (~div_remainder + 20'd1) : div_remainder;

   assign hit_time  = (tss_ff >= interval_ff);
   assign hit_delta = (mag_ff >= {32'd0, thr_ff});

   // saturate |acc|/10 with the sign of acc to int32
   always_comb begin
      if (!acc_ff[63]) begin
         sat_charge = (div_quotient > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF
                                                              : div_quotient[31:0];
      end else begin
         sat_charge = (div_quotient > 64'h0000_0000_8000_0000) ? 32'h8000_0000
                                                              : (~div_quotient[31:0] + 32'd1);
      end
   end

   // ------------------------------------------------------------------------
   // Serial units
   // ------------------------------------------------------------------------
   tcc_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (avg_ff),
      .multiplier   (dt_ff),
      .product      (mul_product),
      .busy         (mul_busy),
      .done         (mul_done)
   );

   tcc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .dividend  (div_dividend),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .busy      (div_busy),
      .done      (div_done)
   );

   // ------------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcc_pkg::ST_IDLE: begin
            if (req_beat) state_in = tcc_pkg::ST_DECODE;
         end
         tcc_pkg::ST_DECODE: begin
            if (action_ff == tcc_pkg::ACT_RESTORE) begin
               state_in = tcc_pkg::ST_ODIV_GO;
            end else if (!ready_ff) begin
               state_in = tcc_pkg::ST_DONE;
            end else if ((action_ff == tcc_pkg::ACT_SAMPLE) && integrate) begin
               state_in = tcc_pkg::ST_MUL_GO;
            end else begin
               state_in = tcc_pkg::ST_ODIV_GO;
            end
         end
         tcc_pkg::ST_MUL_GO:    state_in = tcc_pkg::ST_MUL_WAIT;
         tcc_pkg::ST_MUL_WAIT: begin
            if (mul_done) state_in = tcc_pkg::ST_NUM;
         end
         tcc_pkg::ST_NUM:       state_in = tcc_pkg::ST_QDIV_GO;
         tcc_pkg::ST_QDIV_GO:   state_in = tcc_pkg::ST_QDIV_WAIT;
         tcc_pkg::ST_QDIV_WAIT: begin
            if (div_done) state_in = tcc_pkg::ST_APPLY;
         end
         tcc_pkg::ST_APPLY:     state_in = tcc_pkg::ST_DIFF;
         tcc_pkg::ST_DIFF:      state_in = tcc_pkg::ST_MAG;
         tcc_pkg::ST_MAG:       state_in = tcc_pkg::ST_CHECK;
         tcc_pkg::ST_CHECK:     state_in = tcc_pkg::ST_ODIV_GO;
         tcc_pkg::ST_ODIV_GO:   state_in = tcc_pkg::ST_ODIV_WAIT;
         tcc_pkg::ST_ODIV_WAIT: begin
            if (div_done) state_in = tcc_pkg::ST_SAT;
         end
         tcc_pkg::ST_SAT:       state_in = tcc_pkg::ST_DONE;
         tcc_pkg::ST_DONE: begin
            if (rsp_load) state_in = tcc_pkg::ST_IDLE;
         end
         default:               state_in = tcc_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer: outputs
   // ------------------------------------------------------------------------
   always_comb begin
      req_tready      = 1'b0;
      mul_start       = 1'b0;
      div_cmd.start   = 1'b0;
      div_cmd.count   = tcc_pkg::ODIV_STEPS;
      div_cmd.divisor = tcc_pkg::DIVISOR_O;
      div_dividend    = acc_abs;
      case (state_ff)
         tcc_pkg::ST_IDLE:    req_tready = 1'b1;
         tcc_pkg::ST_MUL_GO:  mul_start  = 1'b1;
         tcc_pkg::ST_QDIV_GO: begin
            // |num| left-aligned so 49 steps leave the quotient in the low bits
            div_cmd.start   = 1'b1;
            div_cmd.count   = tcc_pkg::QDIV_STEPS;
            div_cmd.divisor = tcc_pkg::DIVISOR_Q;
            div_dividend    = {num_abs, 15'd0};
         end
         tcc_pkg::ST_ODIV_GO: div_cmd.start = 1'b1;
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // Control and counter state
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         interval_ff  <= tcc_pkg::INTERVAL_RESET;
         thr_ff       <= tcc_pkg::DELTA_RESET;
         acc_ff       <= '0;
         rem_ff       <= '0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         ready_ff     <= 1'b0;
         saved_ff     <= '0;
         tss_ff       <= '0;
      end else begin
         state_ff <= state_in;

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write) begin
            if (csr_paddr[2] == tcc_pkg::REG_DELTA) begin
               thr_ff <= csr_pwdata;
            end else begin
               interval_ff <= csr_pwdata;
            end
         end

         case (state_ff)
            tcc_pkg::ST_DECODE: begin
               if (action_ff == tcc_pkg::ACT_RESTORE) begin
                  acc_ff       <= preset_x10;
                  saved_ff     <= preset_x10;
                  rem_ff       <= '0;
                  prev_ff      <= '0;
                  have_prev_ff <= 1'b0;
                  ready_ff     <= 1'b1;
                  tss_ff       <= '0;
               end else if (!ready_ff) begin
                  // uninitialised: state untouched
               end else if (action_ff == tcc_pkg::ACT_SET) begin
                  acc_ff   <= preset_x10;
                  saved_ff <= preset_x10;
                  tss_ff   <= '0;
               end else if ((action_ff == tcc_pkg::ACT_SAMPLE) && !integrate) begin
                  // first sample or zero dt: record current only
                  prev_ff      <= cur_ff;
                  have_prev_ff <= 1'b1;
               end
            end
            tcc_pkg::ST_APPLY: begin
               acc_ff  <= acc_ff + (div_quotient ^ delta_mask) + {63'd0, num_ff[48]};
               rem_ff  <= rem_signed;
               prev_ff <= cur_ff;
               tss_ff  <= tss_ff + {16'd0, dt_ff};
            end
            tcc_pkg::ST_CHECK: begin
               if (hit_time || hit_delta) begin
                  saved_ff <= acc_ff;
                  tss_ff   <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Payload registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_beat) begin
         action_ff <= req_tuser;
         cur_ff    <= req_tdata[31:0];
         dt_ff     <= req_tdata[47:32];
         preset_ff <= req_tdata[79:48];
      end

      case (state_ff)
         tcc_pkg::ST_DECODE: begin
            avg_ff    <= avg_next;
            status_ff <= !ready_ff && (action_ff != tcc_pkg::ACT_RESTORE);
            save_ff   <= ready_ff && (action_ff == tcc_pkg::ACT_SET);
            charge_ff <= '0;
         end
         tcc_pkg::ST_NUM: begin
            num_ff <= {mul_product[47], mul_product} + {{29{rem_ff[19]}}, rem_ff};
         end
         tcc_pkg::ST_DIFF:  diff_ff <= acc_ff - saved_ff;
         tcc_pkg::ST_MAG:   mag_ff  <= diff_ff[63] ? (~diff_ff + 64'd1) : diff_ff;
         tcc_pkg::ST_CHECK: save_ff <= hit_time || hit_delta;
         tcc_pkg::ST_SAT:   charge_ff <= sat_charge;
         default: ;
      endcase

      if (rsp_load) begin
         rsp_charge_ff <= charge_ff;
         rsp_save_ff   <= save_ff;
         rsp_status_ff <= status_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // serial units are quiet whenever a new beat may be taken
   a_idle_units: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcc_pkg::ST_IDLE) |-> (!mul_busy && !div_busy))
      else $error("serial unit busy while idle");

   // before a restore nothing integrates or ages
   a_uninit_quiet: assert property (@(posedge clock) disable iff (reset)
      !ready_ff |-> ((acc_ff == 64'd0) && (tss_ff == 32'd0) && (rem_ff == 20'd0)))
      else $error("state moved before restore");

   // carried remainder stays strictly inside the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      ($signed(rem_ff) < $signed(20'sd360000)) && ($signed(rem_ff) > -$signed(20'sd360000)))
      else $error("remainder out of range");

   // an uninitialised result carries zero charge and no save
   a_uninit_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> ((rsp_charge_ff == 32'd0) && !rsp_save_ff))
      else $error("uninitialised result not cleared");

endmodule

// ===== verif/trapezoidal_coulomb_counter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// trapezoidal_coulomb_counter_unit_tb
// Self-checking bench for the trapezoidal coulomb counter. A queue-fed driver
// offers request beats, a charge predictor runs alongside and a monitor
// checks every result beat against it, over several save threshold settings.
// ----------------------------------------------------------------------------
module trapezoidal_coulomb_counter_unit_tb;

   // Unused action code; the package only names the three real ones
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Trapezoid step divisor, 0.01 mA x ms -> 0.001 mAh
   localparam longint CHARGE_DIV   = 360000;
   localparam int     LIMIT_CYCLES = 800000;
   localparam int     DRAIN_CYCLES = 160;   // a little over the worst latency
   localparam int     HOLD_CYCLES  = 1500;  // receiver back-pressure stretch

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] current;   // 0.01 mA, signed
      logic [15:0] dt;        // ms
      logic [31:0] preset;    // 0.01 mAh, signed
   } req_item_type;

   typedef struct packed {
      logic        status;
      logic [31:0] charge;    // 0.01 mAh, signed, saturated
      logic        save;
   } charge_item_type;

   logic        clock;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;  // [31:0] sample_current, [47:32] dt_ms,
                                 // [79:48] preset_mah_x100
   logic [1:0]  req_tuser = '0;  // [1:0] action

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;       // [31:0] charge_mah_x100, [32] save_request,
                                 // [39:33] zero
   logic        rsp_tuser;       // [0] status

   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   trapezoidal_coulomb_counter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------------
   // Predictor state: a private copy of the counter and its thresholds
   // ------------------------------------------------------------------------
   logic [31:0] interval_ms = tcc_pkg::INTERVAL_RESET;
   logic [31:0] delta_umah  = tcc_pkg::DELTA_RESET;
   longint      acc_umah    = 0;   // charge, 0.001 mAh, wraps at 64 bits
   longint      carry       = 0;   // signed remainder of the last divide
   longint      prev_cur    = 0;
   logic        have_prev   = 1'b0;
   logic        ready       = 1'b0;
   longint      saved_umah  = 0;
   logic [31:0] since_save  = '0;

   req_item_type    pending[$];       // beats waiting for the driver
   charge_item_type charge_due[$];    // predicted results, oldest first
   req_item_type    on_offer;

   int issued     = 0;
   int accepted   = 0;
   int checked    = 0;
   int mismatches = 0;
   int n_sample = 0, n_set = 0, n_restore = 0, n_unused = 0, n_unready = 0;
   int n_saves = 0, n_sat = 0;

   logic calm     = 1'b0;   // no idling on either side while set
   logic hold_off = 1'b0;   // receiver refuses all beats while set

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Charge predictor: one accepted request beat -> one expected result
   // ------------------------------------------------------------------------
   task automatic predict_charge(input req_item_type b);
      longint          cur64, avg, num, step, quot, dt64;
      logic [63:0]     swing;
      charge_item_type r;
      r     = '0;
      cur64 = longint'($signed(b.current));
      dt64  = longint'(b.dt);
      case (b.action)
         tcc_pkg::ACT_SAMPLE:  n_sample++;
         tcc_pkg::ACT_SET:     n_set++;
         tcc_pkg::ACT_RESTORE: n_restore++;
         default:              n_unused++;
      endcase

      if (b.action == tcc_pkg::ACT_RESTORE) begin
         acc_umah   = longint'($signed(b.preset)) * 64'sd10;
         carry      = 0;
         prev_cur   = 0;
         have_prev  = 1'b0;
         ready      = 1'b1;
         saved_umah = acc_umah;
         since_save = '0;
      end else if (!ready && b.action != ACT_UNUSED) begin
         // not initialised: sample and set leave everything untouched
      end else if (b.action == tcc_pkg::ACT_SET) begin
         // remainder is kept across a set
         acc_umah   = longint'($signed(b.preset)) * 64'sd10;
         saved_umah = acc_umah;
         since_save = '0;
         r.save     = 1'b1;
      end else if (b.action == tcc_pkg::ACT_SAMPLE) begin
         if (!have_prev || b.dt == 16'd0) begin
            // first sample or zero dt just records the current
            prev_cur  = cur64;
            have_prev = 1'b1;
         end else begin
            avg        = (prev_cur + cur64) / 64'sd2;   // truncates toward zero
            num        = avg * dt64 + carry;
            step       = num / CHARGE_DIV;
            carry      = num - step * CHARGE_DIV;
            acc_umah   = acc_umah + step;
            prev_cur   = cur64;
            since_save = since_save + {16'd0, b.dt};
            swing      = acc_umah - saved_umah;
            if (swing[63])
               swing = -swing;
            if (since_save >= interval_ms || swing >= {32'd0, delta_umah}) begin
               saved_umah = acc_umah;
               since_save = '0;
               r.save     = 1'b1;
            end
         end
      end

      if (!ready) begin
         r.status = 1'b1;
         n_unready++;
      end else begin
         quot = acc_umah / 64'sd10;
         if (quot > 64'sd2147483647) begin
            quot = 64'sd2147483647;
            n_sat++;
         end else if (quot < -64'sd2147483648) begin
            quot = -64'sd2147483648;
            n_sat++;
         end
         r.charge = quot[31:0];
      end
      if (r.save)
         n_saves++;
      charge_due.push_back(r);
   endtask

   // ------------------------------------------------------------------------
   // Request driver: offers queued beats, idles at random unless calm.
   // The held beat is only replaced once the current one has been taken.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_charge(on_offer);
            accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
               on_offer    = pending.pop_front();
               req_tdata  <= {on_offer.preset, on_offer.dt, on_offer.current};
               req_tuser  <= on_offer.action;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: checks each beat against the oldest prediction
   // ------------------------------------------------------------------------
   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH result %0d %s: expected %0d (0x%h), got %0d (0x%h)",
                     checked, what, $signed(want), want, $signed(got), got);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      charge_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (charge_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("MISMATCH unexpected result beat: status %b charge %0d save %b",
                           rsp_tuser, $signed(rsp_tdata[31:0]), rsp_tdata[32]);
            end else begin
               want = charge_due.pop_front();
               compare_field("status", {31'd0, want.status}, {31'd0, rsp_tuser});
               compare_field("charge_mah_x100", want.charge, rsp_tdata[31:0]);
               compare_field("save_request", {31'd0, want.save}, {31'd0, rsp_tdata[32]});
               checked++;
            end
         end
         rsp_tready <= !hold_off && (calm || $urandom_range(99) >= 24);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_beat(input logic [1:0] action, input logic [31:0] current,
                            input logic [15:0] dt, input logic [31:0] preset);
      pending.push_back('{action: action, current: current, dt: dt, preset: preset});
      issued++;
   endtask

   // Register writes only happen with the block idle; the predictor copy
   // follows at the same point.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr[2] == tcc_pkg::REG_INTERVAL)
         interval_ms = data;
      else
         delta_umah = data;
   endtask

   task automatic set_thresholds(input logic [31:0] interval, input logic [31:0] delta);
      csr_write({tcc_pkg::REG_INTERVAL, 2'b00}, interval);
      csr_write({tcc_pkg::REG_DELTA, 2'b00}, delta);
   endtask

   // Wait until every queued beat is taken and every result has come back
   task automatic drain;
      while (accepted != issued || charge_due.size() != 0)
         @(posedge clock);
   endtask

   // One random phase: opens with a restore so the counter is live, then
   // mostly samples with the odd set, restore or unused code mixed in.
   task automatic random_phase(input int n);
      int          k, pick;
      logic [1:0]  act;
      logic [31:0] cur, pre;
      logic [15:0] dt;
      for (k = 0; k <= n; k++) begin
         pick = $urandom_range(99);
         if (k == 0 || (pick >= 87 && pick < 93))
            act = tcc_pkg::ACT_RESTORE;
         else if (pick < 80)
            act = tcc_pkg::ACT_SAMPLE;
         else if (pick < 87)
            act = tcc_pkg::ACT_SET;
         else
            act = ACT_UNUSED;

         pick = $urandom_range(99);
         if (pick < 40)
            cur = $urandom_range(400000) - 200000;
         else if (pick < 70)
            cur = $urandom;
         else if (pick < 85)
            cur = $urandom_range(100000000) - 50000000;
         else
            cur = pick[0] ? 32'h7fff_ffff : 32'h8000_0000;

         pick = $urandom_range(99);
         if (pick < 60)
            dt = 16'($urandom_range(5000, 1));
         else if (pick < 70)
            dt = 16'd0;
         else if (pick < 90)
            dt = 16'($urandom_range(65535));
         else
            dt = 16'hffff;

         pick = $urandom_range(99);
         if (pick < 50)
            pre = $urandom_range(200000) - 100000;
         else if (pick < 90)
            pre = $urandom;
         else
            pre = pick[0] ? 32'h7fff_ffff : 32'h8000_0000;

         push_beat(act, cur, dt, pre);
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: before init, restore, first sample, zero dt, the trapezoid
      // rounding, current and dt extremes, positive saturation and the most negative charge.
      push_beat(tcc_pkg::ACT_SAMPLE,  32'd1000, 16'd10, 32'd0);
      push_beat(tcc_pkg::ACT_SET,     32'd0, 16'd0, 32'd5);
      push_beat(ACT_UNUSED,           32'hffff_ffff, 16'hffff, 32'hffff_ffff);
      push_beat(tcc_pkg::ACT_RESTORE, 32'd0, 16'd0, 32'd0);
      push_beat(ACT_UNUSED,           32'd0, 16'd0, 32'd0);
      push_beat(tcc_pkg::ACT_SAMPLE,  32'd100000, 16'd100, 32'd0);
      push_beat(tcc_pkg::ACT_SAMPLE,  32'd200000, 16'd0, 32'd0);
      push_beat(tcc_pkg::ACT_SAMPLE,  32'd300000, 16'd1000, 32'd0);
      push_beat(tcc_pkg::ACT_SAMPLE,  -32'sd300000, 16'hffff, 32'd0);
      push_beat(tcc_pkg::ACT_SAMPLE,  32'h8000_0000, 16'hffff, 32'd0);
      push_beat(tcc_pkg::ACT_SAMPLE,  32'h7fff_ffff, 16'hffff, 32'd0);
      push_beat(tcc_pkg::ACT_SET,     32'd0, 16'd0, 32'h7fff_ffff);
      push_beat(tcc_pkg::ACT_SAMPLE,  32'h7fff_ffff, 16'hffff, 32'd0);
      push_beat(tcc_pkg::ACT_SAMPLE,  32'h7fff_ffff, 16'hffff, 32'd0);
      push_beat(tcc_pkg::ACT_SET,     32'd0, 16'd0, 32'h8000_0000);
      push_beat(tcc_pkg::ACT_SAMPLE,  32'h8000_0000, 16'hffff, 32'd0);
      push_beat(tcc_pkg::ACT_RESTORE, 32'd0, 16'd0, -32'sd12345);
      push_beat(tcc_pkg::ACT_SAMPLE,  -32'sd7, 16'd1, 32'd0);
      push_beat(tcc_pkg::ACT_SAMPLE,  -32'sd8, 16'd1, 32'd0);   // average -7.5 -> -7
      push_beat(tcc_pkg::ACT_SAMPLE,  32'd3, 16'd3, 32'd0);     // remainder carried
      push_beat(tcc_pkg::ACT_RESTORE, 32'd0, 16'd0, 32'h7fff_ffff);
      push_beat(tcc_pkg::ACT_RESTORE, 32'd0, 16'd0, 32'h8000_0000);
      drain();

      // Smallest nonzero thresholds: every integrating step saves
      set_thresholds(32'd1, 32'd1);
      random_phase(85);
      drain();

      // Zero thresholds are always reached
      set_thresholds(32'd0, 32'd0);
      random_phase(85);
      drain();

      // Largest thresholds, and a stretch with no idling on either side
      set_thresholds(32'hffff_ffff, 32'hffff_ffff);
      @(posedge clock);
      calm <= 1'b1;
      random_phase(85);
      drain();
      calm <= 1'b0;

      set_thresholds($urandom_range(200000, 1), $urandom_range(50000, 1));
      random_phase(85);
      drain();

      // Back to the reset values; the receiver stalls for a long stretch
      // while the driver keeps offering, so the block backs up its input.
      set_thresholds(tcc_pkg::INTERVAL_RESET, tcc_pkg::DELTA_RESET);
      random_phase(85);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
      drain();

      // Let any stray result beat surface before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d beats: %0d samples, %0d sets, %0d restores,",
               accepted, n_sample, n_set, n_restore);
      $display("  %0d unused code, %0d before init; %0d results checked over 6 settings,",
               n_unused, n_unready, checked);
      $display("  %0d save requests, %0d saturated", n_saves, n_sat);
      if (mismatches == 0 && charge_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatches, charge_due.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_CYCLES * 12);
      $display("watchdog expired: %0d of %0d beats taken, %0d results outstanding",
               accepted, issued, charge_due.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
